// ===== design/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
package ffba_pkg;

  localparam int CountW   = 11;
  localparam int InAddrW  = 16;
  localparam int OutAddrW = 10;
  localparam int StatusW  = 3;

  localparam logic [StatusW-1:0] ST_OK      = 3'd0;
  localparam logic [StatusW-1:0] ST_NULL    = 3'd1;
  localparam logic [StatusW-1:0] ST_OUTSIDE = 3'd2;
  localparam logic [StatusW-1:0] ST_NOSPACE = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL    = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_G_CHK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_DECIDE,
    S_SH_RD,
    S_SH_WR,
    S_INS_WR,
    S_RESP
  } state_t;

endpackage

// ===== design/first_fit_block_allocator_top.sv =====
// First-fit block allocator: free-segment table sequencer over two RAMs.
//
//  channel | dir | fields
//  s_*     | in  | tdata: block_count[10:0] block_addr[26:11]; tuser: action[0] null_ptr[1]
//  m_*     | out | tdata: status[2:0] alloc_addr[12:3]
//
// One request at a time. A request scans the free-table entries in order as needed,
// then shifts entries on insert or remove; the next request is accepted only after
// the result is loaded into the output register. Reset is synchronous; table
// entry zero reads as the whole heap until first written. A stalled result holds
// in the output register while the next request is computed.
module first_fit_block_allocator_top import ffba_pkg::*; #(
  parameter int HEAP_BLOCKS  = 1024,
  parameter int FREE_ENTRIES = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // block_count[10:0], block_addr[26:11], zero pad
  input  logic [1:0]  s_tuser,   // action[0], null_ptr[1]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // status[2:0], alloc_addr[12:3], zero pad
);

  localparam int AW = $clog2(HEAP_BLOCKS);
  localparam int LW = $clog2(HEAP_BLOCKS + 1);
  localparam int SW = LW + 1;
  localparam int MW = (LW > CountW) ? LW : CountW;
  localparam int XW = $clog2(FREE_ENTRIES);
  localparam int IW = $clog2(FREE_ENTRIES + 1);
  localparam int TW = AW + LW;

  function automatic logic [LW-1:0] clamp_len(input logic [AW-1:0] st,
                                               input logic [SW-1:0] len);
    logic [SW-1:0] room;
    room = SW'(HEAP_BLOCKS) - SW'(st);
    return (len > room) ? LW'(room) : LW'(len);
  endfunction

  state_t state, state_next;
  logic            op, op_next;
  logic [MW-1:0]   n, n_next;
  logic [AW-1:0]   a, a_next;
  logic [LW-1:0]   size, size_next;
  logic [IW-1:0]   count, count_next;
  logic [IW-1:0]   idx, idx_next;
  logic [IW-1:0]   sp, sp_next;
  logic            down, down_next;
  logic            has_prev, has_prev_next;
  logic [AW-1:0]   prev_s, prev_s_next;
  logic [LW-1:0]   prev_l, prev_l_next;
  logic            has_cur, has_cur_next;
  logic [AW-1:0]   cur_s, cur_s_next;
  logic [LW-1:0]   cur_l, cur_l_next;
  logic [StatusW-1:0] status, status_next;
  logic [AW-1:0]   grant, grant_next;
  logic            e0_dirty;
  logic [XW-1:0]   rd_idx_q;
  logic            out_valid;
  logic [15:0]     out_data;
  logic            out_load;

  logic            t_we;
  logic [XW-1:0]   t_waddr, t_raddr;
  logic [TW-1:0]   t_wdata, t_rdata, entry;
  logic            g_we;
  logic [AW-1:0]   g_waddr, g_raddr;
  logic [LW-1:0]   g_wdata, g_rdata;

  logic [AW-1:0]   es;
  logic [LW-1:0]   el;
  logic            prev_adj, next_adj;
  logic [LW-1:0]   l1, l2, ln;

  ffba_ram #(.WIDTH(TW), .DEPTH(FREE_ENTRIES)) u_tbl (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  ffba_ram #(.WIDTH(LW), .DEPTH(HEAP_BLOCKS)) u_gnt (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .raddr(g_raddr), .rdata(g_rdata)
  );

  assign entry = (rd_idx_q == '0 && !e0_dirty) ? {AW'(0), LW'(HEAP_BLOCKS)} : t_rdata;
  assign es = entry[TW-1:LW];
  assign el = entry[LW-1:0];

  assign prev_adj = has_prev && (SW'(prev_s) + SW'(prev_l) == SW'(a));
  assign next_adj = has_cur && (SW'(a) + SW'(size) == SW'(cur_s));
  assign l1 = clamp_len(prev_s, SW'(prev_l) + SW'(size));
  assign l2 = clamp_len(prev_s, SW'(l1) + SW'(cur_l));
  assign ln = clamp_len(a, SW'(size) + SW'(cur_l));

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;
  assign out_load = (state == S_RESP) && (!out_valid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= IW'(1);
      e0_dirty <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (t_we && t_waddr == '0) begin
        e0_dirty <= 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op       <= op_next;
    n        <= n_next;
    a        <= a_next;
    size     <= size_next;
    idx      <= idx_next;
    sp       <= sp_next;
    down     <= down_next;
    has_prev <= has_prev_next;
    prev_s   <= prev_s_next;
    prev_l   <= prev_l_next;
    has_cur  <= has_cur_next;
    cur_s    <= cur_s_next;
    cur_l    <= cur_l_next;
    status   <= status_next;
    grant    <= grant_next;
    rd_idx_q <= t_raddr;
    if (out_load) begin
      out_data <= {3'b000, OutAddrW'(grant), status};
    end
  end

  always_comb begin
    state_next    = state;
    op_next       = op;
    n_next        = n;
    a_next        = a;
    size_next     = size;
    count_next    = count;
    idx_next      = idx;
    sp_next       = sp;
    down_next     = down;
    has_prev_next = has_prev;
    prev_s_next   = prev_s;
    prev_l_next   = prev_l;
    has_cur_next  = has_cur;
    cur_s_next    = cur_s;
    cur_l_next    = cur_l;
    status_next   = status;
    grant_next    = grant;
    t_we    = 1'b0;
    t_waddr = XW'(idx);
    t_wdata = entry;
    t_raddr = XW'(idx);
    g_we    = 1'b0;
    g_waddr = es;
    g_wdata = LW'(n);
    g_raddr = AW'(s_tdata[26:11]);

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          op_next       = s_tuser[0];
          n_next        = MW'(s_tdata[10:0]);
          a_next        = AW'(s_tdata[26:11]);
          grant_next    = '0;
          idx_next      = '0;
          has_prev_next = 1'b0;
          has_cur_next  = 1'b0;
          status_next   = ST_OK;
          if (s_tuser[0] == OP_ALLOC) begin
            if (s_tdata[10:0] == '0 || count == '0) begin
              status_next = ST_NOSPACE;
              state_next  = S_RESP;
            end else begin
              state_next = S_SCAN_RD;
            end
          end else if (s_tuser[1]) begin
            status_next = ST_NULL;
            state_next  = S_RESP;
          end else if ({1'b0, s_tdata[26:11]} >= 17'(HEAP_BLOCKS)) begin
            status_next = ST_OUTSIDE;
            state_next  = S_RESP;
          end else begin
            state_next = S_G_CHK;
          end
        end
      end
      S_G_CHK: begin
        size_next = clamp_len(a, SW'(g_rdata));
        if (clamp_len(a, SW'(g_rdata)) == '0) begin
          state_next = S_RESP;
        end else if (count == '0) begin
          state_next = S_DECIDE;
        end else begin
          state_next = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (op == OP_ALLOC) begin
          if (MW'(el) >= n) begin
            grant_next = es;
            g_we       = 1'b1;
            state_next = S_RESP;
            if (MW'(el) == n) begin
              if (idx + 1'b1 < count) begin
                sp_next    = idx;
                down_next  = 1'b1;
                state_next = S_SH_RD;
              end else begin
                count_next = count - 1'b1;
              end
            end else begin
              t_we    = 1'b1;
              t_wdata = {AW'(MW'(es) + n), LW'(MW'(el) - n)};
            end
          end else if (idx + 1'b1 == count) begin
            status_next = ST_NOSPACE;
            state_next  = S_RESP;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = S_SCAN_RD;
          end
        end else begin
          if (es < a) begin
            has_prev_next = 1'b1;
            prev_s_next   = es;
            prev_l_next   = el;
            idx_next      = idx + 1'b1;
            state_next    = (idx + 1'b1 == count) ? S_DECIDE : S_SCAN_RD;
          end else begin
            has_cur_next = 1'b1;
            cur_s_next   = es;
            cur_l_next   = el;
            state_next   = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        if (prev_adj) begin
          t_we       = 1'b1;
          t_waddr    = XW'(idx - 1'b1);
          t_wdata    = {prev_s, next_adj ? l2 : l1};
          state_next = S_RESP;
          if (next_adj) begin
            if (idx + 1'b1 < count) begin
              sp_next    = idx;
              down_next  = 1'b1;
              state_next = S_SH_RD;
            end else begin
              count_next = count - 1'b1;
            end
          end
        end else if (next_adj) begin
          t_we       = 1'b1;
          t_wdata    = {a, ln};
          state_next = S_RESP;
        end else if (count >= IW'(FREE_ENTRIES)) begin
          status_next = ST_FULL;
          state_next  = S_RESP;
        end else if (count == idx) begin
          state_next = S_INS_WR;
        end else begin
          sp_next    = count;
          down_next  = 1'b0;
          state_next = S_SH_RD;
        end
      end
      S_SH_RD: begin
        t_raddr    = down ? XW'(sp + 1'b1) : XW'(sp - 1'b1);
        state_next = S_SH_WR;
      end
      S_SH_WR: begin
        t_we    = 1'b1;
        t_waddr = XW'(sp);
        t_wdata = entry;
        if (down) begin
          sp_next = sp + 1'b1;
          if ({1'b0, sp} + 2'd2 == {1'b0, count}) begin
            count_next = count - 1'b1;
            state_next = S_RESP;
          end else begin
            state_next = S_SH_RD;
          end
        end else begin
          sp_next    = sp - 1'b1;
          state_next = (sp - 1'b1 == idx) ? S_INS_WR : S_SH_RD;
        end
      end
      S_INS_WR: begin
        t_we       = 1'b1;
        t_wdata    = {a, size};
        count_next = count + 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (!out_valid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ffba_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ffba_checker.sv =====
// Port-level checks for the first-fit block allocator, bound to the top level.
module ffba_checker import ffba_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata
);

  a_rst_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  a_addr_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[12:3] == '0)
    else $error("failed request carries an address");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request taken while previous one in progress");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for the first-fit block allocator.
`timescale 1ns / 100ps

module testbench;
  import ffba_pkg::*;

  localparam int HEAP    = 1024;
  localparam int ENTRIES = 64;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;

  typedef struct packed {
    logic [StatusW-1:0]  status;
    logic [OutAddrW-1:0] addr;
  } answer_t;

  answer_t answer_q[$];
  int      seg_start[ENTRIES];
  int      seg_len[ENTRIES];
  int      seg_count;
  int      granted[HEAP];
  int      live_q[$];
  int      errors = 0;
  int      beats_out = 0;
  int      beats_in = 0;
  int      grants = 0;
  int      fulls = 0;
  bit      rx_busy = 1'b1;

  first_fit_block_allocator_top #(.HEAP_BLOCKS(HEAP), .FREE_ENTRIES(ENTRIES)) i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int clamp_len(int start, int len);
    return (len > HEAP - start) ? HEAP - start : len;
  endfunction

  function automatic void drop_seg(int i);
    for (int k = i; k + 1 < seg_count; k++) begin
      seg_start[k] = seg_start[k+1];
      seg_len[k]   = seg_len[k+1];
    end
    seg_count--;
  endfunction

  function automatic answer_t predict_alloc(int n);
    answer_t r;
    int      s;
    r = '{ST_NOSPACE, '0};
    if (n == 0) return r;
    for (int i = 0; i < seg_count; i++) begin
      if (seg_len[i] >= n) begin
        s = seg_start[i];
        if (seg_len[i] == n) drop_seg(i);
        else begin
          seg_start[i] += n;
          seg_len[i]   -= n;
        end
        granted[s] = n;
        r = '{ST_OK, s[OutAddrW-1:0]};
        return r;
      end
    end
    return r;
  endfunction

  function automatic logic [StatusW-1:0] predict_free(int a);
    int size, stop, i, p;
    bit prev_adj, next_adj;
    size = clamp_len(a, granted[a]);
    if (size == 0) return ST_OK;
    stop = a + size;
    i = 0;
    while (i < seg_count && seg_start[i] < a) i++;
    prev_adj = i > 0 && seg_start[i-1] + seg_len[i-1] == a;
    next_adj = i < seg_count && stop == seg_start[i];
    if (prev_adj) begin
      p = i - 1;
      seg_len[p] = clamp_len(seg_start[p], seg_len[p] + size);
      if (next_adj) begin
        seg_len[p] = clamp_len(seg_start[p], seg_len[p] + seg_len[i]);
        drop_seg(i);
      end
      return ST_OK;
    end
    if (next_adj) begin
      seg_len[i]   = clamp_len(a, size + seg_len[i]);
      seg_start[i] = a;
      return ST_OK;
    end
    if (seg_count >= ENTRIES) return ST_FULL;
    for (int k = seg_count; k > i; k--) begin
      seg_start[k] = seg_start[k-1];
      seg_len[k]   = seg_len[k-1];
    end
    seg_start[i] = a;
    seg_len[i]   = size;
    seg_count++;
    return ST_OK;
  endfunction

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n + 1) @(negedge clk);
  endtask

  task automatic send_beat(logic action, int count, int addr, logic is_null);
    answer_t a;
    a = '{ST_OK, '0};
    if (action == OP_ALLOC) begin
      a = predict_alloc(count);
      if (a.status == ST_OK) begin
        live_q.push_back(a.addr);
        grants++;
      end
    end else if (is_null) a.status = ST_NULL;
    else if (addr >= HEAP) a.status = ST_OUTSIDE;
    else begin
      a.status = predict_free(addr);
      if (a.status == ST_FULL) fulls++;
    end
    answer_q.push_back(a);
    s_tdata  <= {5'd0, addr[15:0], count[10:0]};
    s_tuser  <= {is_null, action};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    beats_in++;
    @(negedge clk);
    s_tvalid <= 1'b0;
    idle_gap();
  endtask

  // free the live segment at the given index of the live queue
  task automatic free_live(int idx);
    int a;
    a = live_q[idx];
    live_q.delete(idx);
    send_beat(OP_FREE, $urandom, a, 1'b0);
  endtask

  task automatic report(string what, answer_t got, answer_t want);
    errors++;
    $display("mismatch %s at beat %0d: got status %0d addr %0d, want status %0d addr %0d",
             what, beats_out, got.status, got.addr, want.status, want.addr);
  endtask

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = '{m_tdata[2:0], m_tdata[12:3]};
      if (answer_q.size() == 0) report("unexpected", got, got);
      else begin
        want = answer_q.pop_front();
        if (got.status != want.status) report("status", got, want);
        else if (got.addr != want.addr) report("alloc_addr", got, want);
      end
      beats_out++;
    end
  end

  always @(negedge clk) begin
    if (!rx_busy) m_tready <= 1'b1;
    else if ($urandom_range(0, 19) == 0) m_tready <= 1'b0;
    else if (!m_tready && $urandom_range(0, 2) != 0) m_tready <= 1'b0;
    else m_tready <= 1'b1;
  end

  task automatic test_directed();
    send_beat(OP_ALLOC, 0, 0, 1'b0);
    send_beat(OP_ALLOC, 1025, 0, 1'b0);
    send_beat(OP_ALLOC, 2047, 65535, 1'b1);
    send_beat(OP_FREE, 0, 5, 1'b1);
    send_beat(OP_FREE, 0, 1024, 1'b0);
    send_beat(OP_FREE, 2047, 65535, 1'b0);
    send_beat(OP_ALLOC, 1024, 0, 1'b0);
    send_beat(OP_ALLOC, 1, 0, 1'b0);
    free_live(0);
    send_beat(OP_ALLOC, 1, 0, 1'b0);
    send_beat(OP_ALLOC, 10, 0, 1'b0);
    send_beat(OP_ALLOC, 20, 0, 1'b0);
    send_beat(OP_ALLOC, 30, 0, 1'b0);
    free_live(1);
    free_live(0);
    free_live(1);
    free_live(0);
    send_beat(OP_ALLOC, 1024, 0, 1'b0);
    free_live(0);
  endtask

  // fragment the heap into single blocks, then free every other to fill the table
  task automatic test_table_full();
    for (int i = 0; i < 140; i++) send_beat(OP_ALLOC, 1, 0, 1'b0);
    send_beat(OP_ALLOC, 900, 0, 1'b0);
    for (int i = 0; i < 140; i += 2) free_live(i - i / 2);
    while (live_q.size() > 0) free_live($urandom_range(0, live_q.size() - 1));
  endtask

  task automatic test_random(int n);
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50 || (pick < 85 && live_q.size() == 0)) begin
        if ($urandom_range(0, 7) == 0) send_beat(OP_ALLOC, $urandom_range(0, 2047), $urandom, 1'b0);
        else send_beat(OP_ALLOC, $urandom_range(1, 40), $urandom, $urandom);
      end else if (pick < 85) free_live($urandom_range(0, live_q.size() - 1));
      else if (pick < 92) send_beat(OP_FREE, $urandom, $urandom, 1'b1);
      else send_beat(OP_FREE, $urandom, $urandom_range(HEAP, 65535), 1'b0);
    end
    while (live_q.size() > 0) free_live($urandom_range(0, live_q.size() - 1));
  endtask

  initial begin
    seg_count = 1;
    seg_start[0] = 0;
    seg_len[0] = HEAP;
    foreach (granted[i]) granted[i] = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_table_full();
    test_random(1300);
    while (answer_q.size() > 0) @(posedge clk);
    rx_busy = 1'b0;
    repeat (300) @(posedge clk);
    $display("sent %0d requests, checked %0d responses", beats_in, beats_out);
    $display("grants %0d, table-full refusals %0d", grants, fulls);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("timeout");
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== first_fit_block_allocator_top.f =====
design/ffba_pkg.sv
design/ffba_ram.sv
design/first_fit_block_allocator_top.sv
design/ffba_checker.sv
tb/testbench.sv
